[rtl/pthc_pkg.sv]
// Shared types, constants and arithmetic helpers for the sensor compensation block.
`default_nettype none
package pthc_pkg;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_TEMP      = 3'd0,
    REG_PRESS_A   = 3'd1,
    REG_PRESS_B   = 3'd2,
    REG_PRESS_HUM = 3'd3,
    REG_HUM       = 3'd4
  } reg_idx_e;

  localparam int unsigned DIV_STAGES = 32;
  localparam int unsigned PRE_STAGES = 11;
  localparam int unsigned POST_STAGES = 4;

  localparam logic [31:0] K_64000   = 32'd64000;
  localparam logic [31:0] K_1048576 = 32'd1048576;
  localparam logic [31:0] K_3125    = 32'd3125;
  localparam logic [31:0] K_76800   = 32'd76800;
  localparam logic [31:0] K_16384   = 32'd16384;
  localparam logic [31:0] K_2097152 = 32'd2097152;
  localparam logic [31:0] K_HUM_MAX = 32'd419430400;
  localparam logic [31:0] K_32768   = 32'd32768;
  localparam logic [31:0] K_8192    = 32'd8192;
  localparam logic [31:0] K_128     = 32'd128;
  localparam logic [31:0] K_5       = 32'd5;

  // One raw reading.
  typedef struct packed {
    logic [19:0] rt;
    logic [19:0] rp;
    logic [15:0] rh;
  } reading_t;

  // Calibration coefficients, each already extended to 32 bits.
  typedef struct packed {
    logic [31:0] t1, t2, t3;
    logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
  } coeff_t;

  // Values that ride alongside the divider.
  typedef struct packed {
    logic [31:0] tc;
    logic [31:0] tf;
    logic [31:0] hx;
    logic        big;
    logic        zero;
  } side_t;

  // Low 32 bits of a product.
  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] r;
    r = {32'd0, a} * {32'd0, b};
    return r[31:0];
  endfunction

  // Arithmetic right shift of a 32-bit word.
  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    return $unsigned($signed(x) >>> n);
  endfunction

endpackage
`default_nettype wire

[rtl/pthc_regs.sv]
// Configuration registers behind the APB-style port and coefficient unpacking.
`default_nettype none
module pthc_regs
  import pthc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready,
  output coeff_t           coeff_o
);

  logic [47:0] temp_q;
  logic [63:0] press_a_q;
  logic [63:0] press_b_q;
  logic [47:0] press_hum_q;
  logic [31:0] hum_q;
  reg_idx_e    idx;
  logic        wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[5:3]);
  assign wr_en  = psel & penable & pwrite;

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q      <= '0;
      press_a_q   <= '0;
      press_b_q   <= '0;
      press_hum_q <= '0;
      hum_q       <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_TEMP:      temp_q      <= pwdata[47:0];
        REG_PRESS_A:   press_a_q   <= pwdata;
        REG_PRESS_B:   press_b_q   <= pwdata;
        REG_PRESS_HUM: press_hum_q <= pwdata[47:0];
        REG_HUM:       hum_q       <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (idx)
      REG_TEMP:      prdata = {16'd0, temp_q};
      REG_PRESS_A:   prdata = press_a_q;
      REG_PRESS_B:   prdata = press_b_q;
      REG_PRESS_HUM: prdata = {16'd0, press_hum_q};
      REG_HUM:       prdata = {32'd0, hum_q};
      default:       prdata = '0;
    endcase
  end

  // Field extraction with sign or zero extension.
  assign coeff_o.t1 = {16'd0, temp_q[15:0]};
  assign coeff_o.t2 = {{16{temp_q[31]}}, temp_q[31:16]};
  assign coeff_o.t3 = {{16{temp_q[47]}}, temp_q[47:32]};
  assign coeff_o.p1 = {16'd0, press_a_q[15:0]};
  assign coeff_o.p2 = {{16{press_a_q[31]}}, press_a_q[31:16]};
  assign coeff_o.p3 = {{16{press_a_q[47]}}, press_a_q[47:32]};
  assign coeff_o.p4 = {{16{press_a_q[63]}}, press_a_q[63:48]};
  assign coeff_o.p5 = {{16{press_b_q[15]}}, press_b_q[15:0]};
  assign coeff_o.p6 = {{16{press_b_q[31]}}, press_b_q[31:16]};
  assign coeff_o.p7 = {{16{press_b_q[47]}}, press_b_q[47:32]};
  assign coeff_o.p8 = {{16{press_b_q[63]}}, press_b_q[63:48]};
  assign coeff_o.p9 = {{16{press_hum_q[15]}}, press_hum_q[15:0]};
  assign coeff_o.h1 = {24'd0, press_hum_q[23:16]};
  assign coeff_o.h2 = {{16{press_hum_q[39]}}, press_hum_q[39:24]};
  assign coeff_o.h3 = {{24{press_hum_q[47]}}, press_hum_q[47:40]};
  assign coeff_o.h4 = {{20{hum_q[11]}}, hum_q[11:0]};
  assign coeff_o.h5 = {{20{hum_q[23]}}, hum_q[23:12]};
  assign coeff_o.h6 = {{24{hum_q[31]}}, hum_q[31:24]};

endmodule
`default_nettype wire

[rtl/pthc_front.sv]
// Two-entry input queue that decouples acceptance from the compute pipeline.
`default_nettype none
module pthc_front
  import pthc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [19:0] raw_temperature_i,
  input  wire logic [19:0] raw_pressure_i,
  input  wire logic [15:0] raw_humidity_i,
  input  wire logic        pop_i,
  output logic             head_valid_o,
  output reading_t         head_o
);

  reading_t   buf_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o   = (cnt_q != 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = buf_q[rd_ptr_q];
  assign push         = in_valid_i & in_ready_o;
  assign pop          = pop_i & head_valid_o;

  // Storage; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= '{rt: raw_temperature_i, rp: raw_pressure_i, rh: raw_humidity_i};
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

[rtl/pthc_div.sv]
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage.
`default_nettype none
module pthc_div
  import pthc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] dvd_i,
  input  wire logic [31:0] dsr_i,
  input  wire side_t       side_i,
  output logic      [31:0] quo_o,
  output side_t            side_o
);

  logic [31:0] rem_q  [DIV_STAGES];
  logic [31:0] quo_q  [DIV_STAGES];
  logic [31:0] dvd_q  [DIV_STAGES];
  logic [31:0] dsr_q  [DIV_STAGES];
  side_t       side_q [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [31:0] rem_in, quo_in, dvd_in, dsr_in;
    side_t       side_in;
    logic [32:0] sh;
    logic        ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign quo_in  = '0;
      assign dvd_in  = dvd_i;
      assign dsr_in  = dsr_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign dvd_in  = dvd_q[k-1];
      assign dsr_in  = dsr_q[k-1];
      assign side_in = side_q[k-1];
    end

    // Shift in the next dividend bit and try a subtract.
    assign sh = {rem_in, dvd_in[31]};
    assign ge = (sh >= {1'b0, dsr_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? 32'(sh - {1'b0, dsr_in}) : sh[31:0];
        quo_q[k]  <= {quo_in[30:0], ge};
        dvd_q[k]  <= {dvd_in[30:0], 1'b0};
        dsr_q[k]  <= dsr_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign quo_o  = quo_q[DIV_STAGES-1];
  assign side_o = side_q[DIV_STAGES-1];

endmodule
`default_nettype wire

[rtl/pthc_core.sv]
// Compensation pipeline: temperature, pressure and humidity arithmetic around the divider.
`default_nettype none
module pthc_core
  import pthc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire coeff_t      coeff_i,
  input  wire logic        head_valid_i,
  input  wire reading_t    head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [31:0] temperature_centi_o,
  output logic      [31:0] fine_temperature_o,
  output logic      [31:0] pressure_pa_o,
  output logic      [16:0] humidity_q10_o
);

  localparam int unsigned Len = PRE_STAGES + DIV_STAGES + POST_STAGES;

  coeff_t        c;
  logic          en;
  logic [Len-1:0] vld_q;

  assign c           = coeff_i;
  assign out_valid_o = vld_q[Len-1];
  assign en          = ~vld_q[Len-1] | out_ready_i;
  assign pop_o       = en;

  // Valid bits move with the data whenever the output can advance.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Len-2:0], head_valid_i};
    end
  end

  logic [31:0] s1_a1, s1_d;
  logic [19:0] s1_rp, s2_rp, s3_rp, s4_rp, s5_rp, s6_rp, s7_rp, s8_rp;
  logic [15:0] s1_rh, s2_rh, s3_rh, s4_rh, s5_rh, s6_rh;
  logic [31:0] s2_m1, s2_dd, s3_v1, s3_m2, s4_tf;
  logic [31:0] s5_pv1, s5_hx, s5_tcm, s5_tf;
  logic [31:0] s6_sq, s6_m5, s6_m2, s6_tc, s6_mh5, s6_b0, s6_c0, s6_tf;
  logic [31:0] s7_v2a, s7_v2b, s7_m3, s7_m2, s7_a, s7_b, s7_c, s7_tc, s7_tf;
  logic [31:0] s8_v2, s8_pv1, s8_bc, s8_a, s8_tc, s8_tf;
  logic [31:0] s9_m1p, s9_pn, s9_e0, s9_a, s9_tc, s9_tf;
  logic [31:0] s10_div, s10_pm, s10_e, s10_a, s10_tc, s10_tf;
  logic [31:0] s11_dvd, s11_div;
  side_t       s11_side;
  logic [31:0] s6_q;

  assign s6_q = asr(s5_pv1, 2);

  // Front half: temperature, then pressure and humidity terms up to the divide.
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_a1 <= ({12'd0, head_i.rt} >> 3) - (c.t1 << 1);
      s1_d  <= ({12'd0, head_i.rt} >> 4) - c.t1;
      s1_rp <= head_i.rp;
      s1_rh <= head_i.rh;

      s2_m1 <= mul32(s1_a1, c.t2);
      s2_dd <= mul32(s1_d, s1_d);
      s2_rp <= s1_rp;
      s2_rh <= s1_rh;

      s3_v1 <= asr(s2_m1, 11);
      s3_m2 <= mul32(asr(s2_dd, 12), c.t3);
      s3_rp <= s2_rp;
      s3_rh <= s2_rh;

      s4_tf <= s3_v1 + asr(s3_m2, 14);
      s4_rp <= s3_rp;
      s4_rh <= s3_rh;

      s5_pv1 <= asr(s4_tf, 1) - K_64000;
      s5_hx  <= s4_tf - K_76800;
      s5_tcm <= mul32(s4_tf, K_5);
      s5_tf  <= s4_tf;
      s5_rp  <= s4_rp;
      s5_rh  <= s4_rh;

      s6_sq  <= mul32(s6_q, s6_q);
      s6_m5  <= mul32(s5_pv1, c.p5);
      s6_m2  <= mul32(c.p2, s5_pv1);
      s6_tc  <= asr(s5_tcm + K_128, 8);
      s6_mh5 <= mul32(c.h5, s5_hx);
      s6_b0  <= mul32(s5_hx, c.h6);
      s6_c0  <= mul32(s5_hx, c.h3);
      s6_tf  <= s5_tf;
      s6_rp  <= s5_rp;
      s6_rh  <= s5_rh;

      s7_v2a <= mul32(asr(s6_sq, 11), c.p6);
      s7_v2b <= s6_m5 << 1;
      s7_m3  <= mul32(c.p3, asr(s6_sq, 13));
      s7_m2  <= s6_m2;
      s7_a   <= asr(({16'd0, s6_rh} << 14) - (c.h4 << 20) - s6_mh5 + K_16384, 15);
      s7_b   <= asr(s6_b0, 10);
      s7_c   <= asr(s6_c0, 11) + K_32768;
      s7_tc  <= s6_tc;
      s7_tf  <= s6_tf;
      s7_rp  <= s6_rp;

      s8_v2  <= asr(s7_v2a + s7_v2b, 2) + (c.p4 << 16);
      s8_pv1 <= asr(asr(s7_m3, 3) + asr(s7_m2, 1), 18);
      s8_bc  <= mul32(s7_b, s7_c);
      s8_a   <= s7_a;
      s8_tc  <= s7_tc;
      s8_tf  <= s7_tf;
      s8_rp  <= s7_rp;

      s9_m1p <= mul32(K_32768 + s8_pv1, c.p1);
      s9_pn  <= (K_1048576 - {12'd0, s8_rp}) - asr(s8_v2, 12);
      s9_e0  <= mul32(asr(s8_bc, 10) + K_2097152, c.h2);
      s9_a   <= s8_a;
      s9_tc  <= s8_tc;
      s9_tf  <= s8_tf;

      s10_div <= asr(s9_m1p, 15);
      s10_pm  <= mul32(s9_pn, K_3125);
      s10_e   <= asr(s9_e0 + K_8192, 14);
      s10_a   <= s9_a;
      s10_tc  <= s9_tc;
      s10_tf  <= s9_tf;

      // Small dividends are doubled before the divide, large ones after.
      s11_dvd       <= s10_pm[31] ? s10_pm : (s10_pm << 1);
      s11_div       <= s10_div;
      s11_side.big  <= s10_pm[31];
      s11_side.zero <= (s10_div == 32'd0);
      s11_side.hx   <= mul32(s10_a, s10_e);
      s11_side.tc   <= s10_tc;
      s11_side.tf   <= s10_tf;
    end
  end

  logic [31:0] d_quo;
  side_t       d_side;

  pthc_div u_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .dvd_i  (s11_dvd),
    .dsr_i  (s11_div),
    .side_i (s11_side),
    .quo_o  (d_quo),
    .side_o (d_side)
  );

  logic [31:0] p1_p, p2_p, p3_p;
  side_t       p1_side, p2_side, p3_side;
  logic [31:0] p2_ps, p2_m8, p2_qq, p3_m9, p3_v2, p3_t;
  logic [31:0] p2_hq, p4_x, p4_hx, p4_pf;

  assign p2_hq = asr(p1_side.hx, 15);
  assign p4_x  = p3_side.hx - asr(p3_t, 4);
  assign p4_pf = p3_p + asr(asr(p3_m9, 12) + p3_v2 + c.p7, 4);

  // Clamp the humidity accumulator before the final shift.
  always_comb begin
    priority if (p4_x[31]) p4_hx = 32'd0;
    else if (p4_x > K_HUM_MAX) p4_hx = K_HUM_MAX;
    else p4_hx = p4_x;
  end

  // Back half: pressure correction and humidity finish, then the output register.
  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_p    <= d_side.big ? (d_quo << 1) : d_quo;
      p1_side <= d_side;

      p2_ps   <= mul32(p1_p >> 3, p1_p >> 3);
      p2_m8   <= mul32(p1_p >> 2, c.p8);
      p2_qq   <= mul32(p2_hq, p2_hq);
      p2_p    <= p1_p;
      p2_side <= p1_side;

      p3_m9   <= mul32(c.p9, p2_ps >> 13);
      p3_v2   <= asr(p2_m8, 13);
      p3_t    <= mul32(asr(p2_qq, 7), c.h1);
      p3_p    <= p2_p;
      p3_side <= p2_side;

      temperature_centi_o <= p3_side.tc;
      fine_temperature_o  <= p3_side.tf;
      pressure_pa_o       <= p3_side.zero ? 32'd0 : p4_pf;
      humidity_q10_o      <= p4_hx[28:12];
    end
  end

endmodule
`default_nettype wire

[rtl/pth_sensor_compensation.sv]
// Top level: 32-bit integer temperature, pressure and humidity compensation.
// Throughput: one reading per cycle when not stalled; the 32-stage divider sets the depth.
// A two-entry input queue absorbs up to two transactions while the output is stalled.
// Reset clears all valid bits, the queue and the coefficient registers to zero.
`default_nettype none
module pth_sensor_compensation
  import pthc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [19:0] raw_temperature_i,
  input  wire logic [19:0] raw_pressure_i,
  input  wire logic [15:0] raw_humidity_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [31:0] temperature_centi_o,
  output logic      [31:0] fine_temperature_o,
  output logic      [31:0] pressure_pa_o,
  output logic      [16:0] humidity_q10_o
);

  coeff_t   coeff;
  logic     head_valid, pop;
  reading_t head;

  pthc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coeff_o (coeff)
  );

  pthc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .raw_temperature_i (raw_temperature_i),
    .raw_pressure_i    (raw_pressure_i),
    .raw_humidity_i    (raw_humidity_i),
    .pop_i             (pop),
    .head_valid_o      (head_valid),
    .head_o            (head)
  );

  pthc_core u_core (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .coeff_i             (coeff),
    .head_valid_i        (head_valid),
    .head_i              (head),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .temperature_centi_o (temperature_centi_o),
    .fine_temperature_o  (fine_temperature_o),
    .pressure_pa_o       (pressure_pa_o),
    .humidity_q10_o      (humidity_q10_o)
  );

endmodule
`default_nettype wire
